// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define SVPWM_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SVPWM_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Types, widths and codes shared by the space-vector PWM duty generator.
// ----------------------------------------------------------------------------
`default_nettype none

package svpwm_pkg;

  localparam int VEC_BITS  = 16;
  localparam int WGT_BITS  = VEC_BITS + 17;
  localparam int SUM_BITS  = WGT_BITS + 1;
  localparam int DUTY_BITS = 16;
  localparam int QUO_BITS  = DUTY_BITS;
  localparam int SQ_BITS   = 2 * VEC_BITS;
  localparam int TRI_FULL  = 2 * VEC_BITS + 2;
  localparam int TRI_BITS  = (TRI_FULL > 64) ? 64 : TRI_FULL;
  localparam int MOD_SHIFT = 15;
  localparam int DIV_STAGES = QUO_BITS;

  localparam logic [15:0] SQRT3_HALF_Q16 = 16'd56756;
  localparam logic [15:0] MOD_ONE        = 16'd32768;
  localparam logic [15:0] PERIOD_RESET   = 16'd3000;

  localparam int APB_ADDR_BITS = 3;
  localparam logic REG_PERIOD   = 1'b0;
  localparam logic REG_POLARITY = 1'b1;

  localparam logic [2:0] SEC_ZERO = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  typedef struct packed {
    logic signed [VEC_BITS-1:0] vec_alpha;
    logic signed [VEC_BITS-1:0] vec_beta;
    logic [15:0]                mod_index;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] compare_a;
    logic [DUTY_BITS-1:0] compare_b;
    logic [DUTY_BITS-1:0] compare_c;
    logic [2:0]           sector_id;
  } out_word_t;

  // Word carried through the divider stages.
  typedef struct packed {
    logic [2:0]           sector;
    logic [DUTY_BITS-1:0] tt;
    logic [DUTY_BITS-1:0] t0;
    logic [DUTY_BITS-1:0] tt_bits;
    logic [WGT_BITS-1:0]  p;
    logic [SUM_BITS-1:0]  d;
    logic [SUM_BITS-1:0]  r;
    logic [QUO_BITS-1:0]  q;
  } div_word_t;

endpackage

`default_nettype wire

// ===== rtl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// svpwm_front
// Four-stage front end: magnitudes, products, sector and weights, weight pair.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  svpwm_pkg::in_word_t    in_word,
  input  logic [15:0]            period,
  output logic                   out_valid,
  input  logic                   out_ready,
  output svpwm_pkg::div_word_t   out_word
);

  localparam int VB  = svpwm_pkg::VEC_BITS;
  localparam int WB  = svpwm_pkg::WGT_BITS;
  localparam int SB  = svpwm_pkg::SUM_BITS;
  localparam int SQW = svpwm_pkg::SQ_BITS;
  localparam int TFW = svpwm_pkg::TRI_FULL;
  localparam int TW  = svpwm_pkg::TRI_BITS;
  localparam int DB  = svpwm_pkg::DUTY_BITS;
  localparam int SAW = VB + 17;
  localparam int SPW = SAW + 1;

  logic rdy1, rdy2, rdy3, rdy4;

  // stage 1
  logic                 s1_valid;
  logic signed [VB-1:0] s1_a, s1_b;
  logic [VB-1:0]        s1_ma, s1_mb;
  logic [15:0]          s1_k;
  logic                 s1_zero;

  // stage 2
  logic                  s2_valid;
  logic [SQW-1:0]        s2_sqa, s2_sqb;
  logic signed [SAW-1:0] s2_sa;
  logic signed [VB-1:0]  s2_b;
  logic [VB-1:0]         s2_mb;
  logic                  s2_zero, s2_apos, s2_bpos;
  logic [DB-1:0]         s2_tt;

  // stage 3
  logic          s3_valid;
  logic [2:0]    s3_sector;
  logic [WB-1:0] s3_w1, s3_w2, s3_w3;
  logic [DB-1:0] s3_tt;

  logic signed [16:0]    sqrt_c;
  logic signed [SAW-1:0] sa_c;
  logic [31:0]           kp;
  logic signed [SPW-1:0] hb, sum_p, sum_m;
  logic [TFW-1:0]        sqa_x;
  logic [TW-1:0]         triple_sq, sqb_x;
  logic                  steep;
  logic [2:0]            sector_c;
  logic [WB-1:0]         p_c, q_c;

  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !s3_valid || rdy4;
  assign rdy2     = !s2_valid || rdy3;
  assign rdy1     = !s1_valid || rdy2;
  assign in_ready = rdy1;

  // ---- stage 1: magnitudes, modulation clamp
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rdy1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_a    <= in_word.vec_alpha;
      s1_b    <= in_word.vec_beta;
      s1_ma   <= in_word.vec_alpha[VB-1] ? VB'(-in_word.vec_alpha) : VB'(in_word.vec_alpha);
      s1_mb   <= in_word.vec_beta[VB-1] ? VB'(-in_word.vec_beta) : VB'(in_word.vec_beta);
      s1_k    <= (in_word.mod_index > svpwm_pkg::MOD_ONE) ? svpwm_pkg::MOD_ONE
                                                          : in_word.mod_index;
      s1_zero <= (in_word.vec_alpha == '0) && (in_word.vec_beta == '0);
    end
  end

  // ---- stage 2: squares, sqrt3/2 * alpha, active time
  assign sqrt_c = $signed({1'b0, svpwm_pkg::SQRT3_HALF_Q16});
  assign sa_c   = SAW'(sqrt_c) * SAW'(s1_a);
  assign kp     = 32'(s1_k) * 32'(period);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (rdy2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_sqa  <= SQW'(s1_ma) * SQW'(s1_ma);
      s2_sqb  <= SQW'(s1_mb) * SQW'(s1_mb);
      s2_sa   <= sa_c;
      s2_b    <= s1_b;
      s2_mb   <= s1_mb;
      s2_zero <= s1_zero;
      s2_apos <= !s1_a[VB-1] && (s1_a != '0);
      s2_bpos <= !s1_b[VB-1] && (s1_b != '0);
      s2_tt   <= kp[svpwm_pkg::MOD_SHIFT +: DB];
    end
  end

  // ---- stage 3: sector and the three weights
  // 3*alpha^2 is held at full width in 34 bits, so it never wraps.
  assign sqa_x     = TFW'(s2_sqa);
  assign triple_sq = TW'((sqa_x << 1) + sqa_x);
  assign sqb_x     = TW'(s2_sqb);
  assign steep     = sqb_x > triple_sq;

  assign hb    = SPW'(s2_b) <<< 15;
  assign sum_p = SPW'(s2_sa) + hb;
  assign sum_m = SPW'(s2_sa) - hb;

  always_comb begin
    if (s2_zero) begin
      sector_c = svpwm_pkg::SEC_ZERO;
    end else if (s2_bpos) begin
      sector_c = steep ? svpwm_pkg::SEC_2 : (s2_apos ? svpwm_pkg::SEC_1 : svpwm_pkg::SEC_3);
    end else begin
      sector_c = steep ? svpwm_pkg::SEC_5 : (s2_apos ? svpwm_pkg::SEC_6 : svpwm_pkg::SEC_4);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (rdy3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_sector <= sector_c;
      s3_w1     <= WB'(s2_mb) << 16;
      s3_w2     <= sum_p[SPW-1] ? WB'(-sum_p) : WB'(sum_p);
      s3_w3     <= sum_m[SPW-1] ? WB'(-sum_m) : WB'(sum_m);
      s3_tt     <= s2_tt;
    end
  end

  // ---- stage 4: pick the weight pair for the sector, zero time
  always_comb begin
    case (s3_sector)
      svpwm_pkg::SEC_1, svpwm_pkg::SEC_4: begin
        p_c = s3_w3;
        q_c = s3_w1;
      end
      svpwm_pkg::SEC_2, svpwm_pkg::SEC_5: begin
        p_c = s3_w2;
        q_c = s3_w3;
      end
      default: begin
        p_c = s3_w1;
        q_c = s3_w2;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rdy4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_word.sector  <= s3_sector;
      out_word.tt      <= s3_tt;
      out_word.t0      <= DB'((period - s3_tt) >> 1);
      out_word.tt_bits <= s3_tt;
      out_word.p       <= p_c;
      out_word.d       <= SB'(p_c) + SB'(q_c);
      out_word.r       <= '0;
      out_word.q       <= '0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_div_step.sv =====
// ----------------------------------------------------------------------------
// svpwm_div_step
// One stage of the t_total * p / sum division: shifts in one bit of t_total,
// folds in p and retires a quotient digit of 0, 1 or 2.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_div_step (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svpwm_pkg::div_word_t in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output svpwm_pkg::div_word_t out_word
);

  localparam int WB = svpwm_pkg::WGT_BITS;
  localparam int SB = svpwm_pkg::SUM_BITS;
  localparam int QB = svpwm_pkg::QUO_BITS;
  localparam int VW = SB + 2;

  logic [WB-1:0] add_p;
  logic [VW-1:0] val, dd1, dd2, rem;
  logic [1:0]    digit;
  svpwm_pkg::div_word_t word_next;

  assign in_ready = !out_valid || out_ready;

  assign add_p = in_word.tt_bits[QB-1] ? in_word.p : '0;
  assign val   = (VW'(in_word.r) << 1) + VW'(add_p);
  assign dd1   = VW'(in_word.d);
  assign dd2   = VW'(in_word.d) << 1;

  // remainder stays below the divisor, so the digit is at most 2
  always_comb begin
    if (val >= dd2) begin
      digit = 2'd2;
      rem   = val - dd2;
    end else if (val >= dd1) begin
      digit = 2'd1;
      rem   = val - dd1;
    end else begin
      digit = 2'd0;
      rem   = val;
    end
  end

  always_comb begin
    word_next         = in_word;
    word_next.tt_bits = in_word.tt_bits << 1;
    word_next.r       = SB'(rem);
    word_next.q       = QB'((in_word.q << 1) + QB'(digit));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_word <= word_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_duty.sv =====
// ----------------------------------------------------------------------------
// svpwm_duty
// Output stage: sector table to phase duties, polarity, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_duty (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  svpwm_pkg::div_word_t in_word,
  input  logic [15:0]          period,
  input  logic                 polarity,
  output logic                 out_valid,
  input  logic                 out_stall,
  output svpwm_pkg::out_word_t out_word
);

  localparam int DB = svpwm_pkg::DUTY_BITS;

  logic [DB-1:0] t0, t1, t2, half;
  logic [DB-1:0] da, db, dc;

  assign in_ready = !out_valid || !out_stall;

  assign t0   = in_word.t0;
  assign t1   = in_word.q;
  assign t2   = in_word.tt - in_word.q;
  assign half = period >> 1;

  always_comb begin
    case (in_word.sector)
      svpwm_pkg::SEC_ZERO: begin
        da = half;
        db = half;
        dc = half;
      end
      svpwm_pkg::SEC_1: begin
        da = t0 + t2 + t1;
        db = t0 + t2;
        dc = t0;
      end
      svpwm_pkg::SEC_2: begin
        da = t0 + t1;
        db = t0 + t1 + t2;
        dc = t0;
      end
      svpwm_pkg::SEC_3: begin
        da = t0;
        db = t0 + t2 + t1;
        dc = t0 + t2;
      end
      svpwm_pkg::SEC_4: begin
        da = t0;
        db = t0 + t1;
        dc = t0 + t1 + t2;
      end
      svpwm_pkg::SEC_5: begin
        da = t0 + t2;
        db = t0;
        dc = t0 + t2 + t1;
      end
      default: begin
        da = t0 + t1 + t2;
        db = t0;
        dc = t0 + t1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_word.compare_a <= polarity ? period - da : da;
      out_word.compare_b <= polarity ? period - db : db;
      out_word.compare_c <= polarity ? period - dc : dc;
      out_word.sector_id <= in_word.sector;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/svpwm_sector_duty_generator.sv =====
// ----------------------------------------------------------------------------
// svpwm_sector_duty_generator
// Seven-segment space-vector PWM: alpha/beta vector in, phase compares out.
// ----------------------------------------------------------------------------
// Usage:
//   in_word carries vec_alpha, vec_beta (Q1.15) and mod_index (Q1.15, clamped
//   to 1.0); a word is taken when in_valid is high and in_stall is low.
//   out_word carries compare_a/b/c and sector_id; it is taken when out_valid
//   is high and out_stall is low.
//   The path runs through 4 front-end stages (magnitudes, products, sector
//   and weights, weight pair), 16 divider stages that each retire one
//   quotient digit (0, 1 or 2) of t_total*p/sum, and the output register.
//   Throughput is one word per cycle while out_stall is low. Every stage
//   holds its own valid bit and loads whenever it is empty or its successor
//   moves, so bubbles fill in while a result waits at the output.
//   When the receiver stalls, the result holds and words pile up behind it;
//   in_stall rises only once every stage is full.
//   Reset clears all valid bits at once (no clearing pass); pwm_period
//   returns to 3000 and output_polarity to 0.
//   Registers (APB, byte address): 0 pwm_period [15:0], 4 output_polarity [0].
//   Write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module svpwm_sector_duty_generator (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  svpwm_pkg::in_word_t                     in_word,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output svpwm_pkg::out_word_t                    out_word,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [svpwm_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [31:0]                             pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready
);

  localparam int NS = svpwm_pkg::DIV_STAGES;

  logic [15:0] pwm_period;
  logic        output_polarity;
  logic        cfg_write;

  svpwm_pkg::div_word_t div_w [0:NS];
  logic                 div_v [0:NS];
  logic                 div_r [0:NS];
  logic                 front_ready;

  // ---- configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period      <= svpwm_pkg::PERIOD_RESET;
      output_polarity <= 1'b0;
    end else if (cfg_write) begin
      if (paddr[2] == svpwm_pkg::REG_PERIOD) begin
        pwm_period <= pwdata[15:0];
      end else begin
        output_polarity <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == svpwm_pkg::REG_POLARITY) ? {31'b0, output_polarity}
                                                        : {16'b0, pwm_period};

  // ---- datapath
  assign in_stall = !front_ready;

  svpwm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (front_ready),
    .in_word   (in_word),
    .period    (pwm_period),
    .out_valid (div_v[0]),
    .out_ready (div_r[0]),
    .out_word  (div_w[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_div
    svpwm_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_v[i]),
      .in_ready  (div_r[i]),
      .in_word   (div_w[i]),
      .out_valid (div_v[i+1]),
      .out_ready (div_r[i+1]),
      .out_word  (div_w[i+1])
    );
  end

  svpwm_duty u_duty (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (div_v[NS]),
    .in_ready  (div_r[NS]),
    .in_word   (div_w[NS]),
    .period    (pwm_period),
    .polarity  (output_polarity),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== rtl/svpwm_checker.sv =====
// ----------------------------------------------------------------------------
// svpwm_checker
// Port-level checks for the duty generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svpwm_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input svpwm_pkg::out_word_t out_word
);

  `SVPWM_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_word), "stalled output word changed")
  `SVPWM_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid, "output valid right after reset")
  `SVPWM_ASSERT(a_stall_full, clk, rst, in_stall |-> out_valid && out_stall, "input stalled while output can move")
  `SVPWM_ASSERT(a_sector_range, clk, rst, out_valid |-> out_word.sector_id <= svpwm_pkg::SEC_6, "sector out of range")
  `SVPWM_ASSERT(a_zero_equal, clk, rst, out_valid && out_word.sector_id == svpwm_pkg::SEC_ZERO |-> out_word.compare_a == out_word.compare_b && out_word.compare_b == out_word.compare_c, "zero vector phases differ")

endmodule

bind svpwm_sector_duty_generator svpwm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire

// ===== bench/svpwm_sector_duty_generator_test.sv =====
// ----------------------------------------------------------------------------
// svpwm_sector_duty_generator_test
// Self-checking bench for the space-vector PWM duty generator. Alpha/beta
// vectors are driven in random bursts while the output side stalls on its
// own schedule. A behavioral duty calculator predicts every output word, and
// the bench runs across several period and polarity settings.
// ----------------------------------------------------------------------------

module svpwm_sector_duty_generator_test;

  localparam int PIPE_DEPTH = 21;
  localparam int IDLE_LIMIT = 4000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_style_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  svpwm_pkg::in_word_t  in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  svpwm_pkg::out_word_t out_word;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [svpwm_pkg::APB_ADDR_BITS-1:0] paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  svpwm_sector_duty_generator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copies of the block's registers
  logic [15:0] period_setting = svpwm_pkg::PERIOD_RESET;
  logic        polarity_setting = 1'b0;

  svpwm_pkg::in_word_t  vectors_to_send[$];
  svpwm_pkg::out_word_t expected_words[$];

  int faults = 0;
  int vectors_sent = 0;
  int words_checked = 0;
  int settings_run = 1;
  int burst_left = 1;
  int gap_left = 0;
  int idle_cycles = 0;
  int mode_left = 0;
  int run_left = 0;
  stall_style_t stall_style = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned magnitude(longint x);
    return (x < 0) ? longint'(-x) : x;
  endfunction

  // Expected compares and sector for one vector under the current settings
  function automatic svpwm_pkg::out_word_t svpwm_duties(svpwm_pkg::in_word_t w);
    longint a, b, sa, hb;
    longint unsigned ma, mb, k, w1, w2, w3, lead, trail, sum;
    int unsigned tt, t1, t2, t0, da, db, dc;
    logic steep;
    logic [2:0] sec;
    svpwm_pkg::out_word_t r;
    a = $signed(w.vec_alpha);
    b = $signed(w.vec_beta);
    k = (w.mod_index > svpwm_pkg::MOD_ONE) ? svpwm_pkg::MOD_ONE : w.mod_index;
    ma = magnitude(a);
    mb = magnitude(b);
    steep = (mb * mb) > (3 * ma * ma);
    if (a == 0 && b == 0) sec = svpwm_pkg::SEC_ZERO;
    else if (b > 0)
      sec = steep ? svpwm_pkg::SEC_2 : ((a > 0) ? svpwm_pkg::SEC_1 : svpwm_pkg::SEC_3);
    else
      sec = steep ? svpwm_pkg::SEC_5 : ((a > 0) ? svpwm_pkg::SEC_6 : svpwm_pkg::SEC_4);

    if (sec == svpwm_pkg::SEC_ZERO) begin
      da = period_setting / 2;
      db = da;
      dc = da;
    end else begin
      sa = longint'(svpwm_pkg::SQRT3_HALF_Q16) * a;
      hb = b * 32768;
      w1 = mb << 16;
      w2 = magnitude(sa + hb);
      w3 = magnitude(sa - hb);
      case (sec)
        svpwm_pkg::SEC_1, svpwm_pkg::SEC_4: begin
          lead = w3;
          trail = w1;
        end
        svpwm_pkg::SEC_2, svpwm_pkg::SEC_5: begin
          lead = w2;
          trail = w3;
        end
        default: begin
          lead = w1;
          trail = w2;
        end
      endcase
      sum = lead + trail;
      tt = 32'((k * period_setting) >> 15);
      t1 = (sum != 0) ? 32'((longint'(tt) * lead) / sum) : 0;
      t2 = tt - t1;
      t0 = (period_setting - tt) / 2;
      case (sec)
        svpwm_pkg::SEC_1: begin da = t0 + t2 + t1; db = t0 + t2; dc = t0; end
        svpwm_pkg::SEC_2: begin da = t0 + t1; db = t0 + t1 + t2; dc = t0; end
        svpwm_pkg::SEC_3: begin da = t0; db = t0 + t2 + t1; dc = t0 + t2; end
        svpwm_pkg::SEC_4: begin da = t0; db = t0 + t1; dc = t0 + t1 + t2; end
        svpwm_pkg::SEC_5: begin da = t0 + t2; db = t0; dc = t0 + t2 + t1; end
        default: begin da = t0 + t1 + t2; db = t0; dc = t0 + t1; end
      endcase
    end

    if (polarity_setting) begin
      da = period_setting - da;
      db = period_setting - db;
      dc = period_setting - dc;
    end
    r.compare_a = da[15:0];
    r.compare_b = db[15:0];
    r.compare_c = dc[15:0];
    r.sector_id = sec;
    return r;
  endfunction

  task automatic queue_vector(int a, int b, int k);
    svpwm_pkg::in_word_t w;
    w.vec_alpha = a[15:0];
    w.vec_beta = b[15:0];
    w.mod_index = k[15:0];
    vectors_to_send.push_back(w);
  endtask

  function automatic int pick_component();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0: return 32767;
      1: return -32768;
      2: return int'($urandom_range(0, 64)) - 32;
      default: return int'($signed(v));
    endcase
  endfunction

  function automatic int pick_mod();
    case ($urandom_range(0, 7))
      0: return 32768;
      1: return 0;
      2: return int'($urandom_range(0, 65535));
      default: return int'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic queue_random(int count);
    int a, b;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          a = 0;
          b = 0;
        end
        1: begin
          a = $urandom_range(0, 1) ? pick_component() : 0;
          b = (a == 0) ? pick_component() : 0;
        end
        2, 3: begin
          // hug the 60 degree line where the sector flips on |beta| vs sqrt3*|alpha|
          a = $urandom_range(0, 18000);
          b = (a * 1732) / 1000 + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1)) a = -a;
          if ($urandom_range(0, 1)) b = -b;
        end
        default: begin
          a = pick_component();
          b = pick_component();
        end
      endcase
      queue_vector(a, b, pick_mod());
    end
  endtask

  task automatic queue_directed();
    // zero vector, with and without mod saturation
    queue_vector(0, 0, 32768);
    queue_vector(0, 0, 65535);
    // axis ties and pure-beta vectors
    queue_vector(32767, 0, 32768);
    queue_vector(-32768, 0, 32768);
    queue_vector(0, 32767, 65535);
    queue_vector(0, -32768, 32769);
    // one vector inside each sector
    queue_vector(20000, 5000, 16384);
    queue_vector(1000, 20000, 16384);
    queue_vector(-20000, 5000, 16384);
    queue_vector(-20000, -5000, 16384);
    queue_vector(-1000, -20000, 16384);
    queue_vector(20000, -5000, 16384);
    // either side of |beta| = sqrt3*|alpha|
    queue_vector(1000, 1732, 30000);
    queue_vector(1000, 1733, 30000);
    queue_vector(-1000, 1732, 30000);
    queue_vector(-1000, 1733, 30000);
    queue_vector(1000, -1733, 30000);
    queue_vector(-1000, -1732, 30000);
    // corners of the input range
    queue_vector(32767, 32767, 0);
    queue_vector(-32768, -32768, 32768);
    queue_vector(-32768, 32767, 1);
    queue_vector(32767, -32768, 65535);
    queue_vector(1, 0, 32768);
    queue_vector(0, -1, 1);
  endtask

  // Hold until every queued vector is in and every word is out, then let the pipe empty
  task automatic settle();
    while (vectors_to_send.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_DEPTH) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_setting(logic [15:0] period, logic polarity, int count);
    settle();
    write_reg(svpwm_pkg::REG_PERIOD, {16'd0, period});
    write_reg(svpwm_pkg::REG_POLARITY, {31'd0, polarity});
    period_setting = period;
    polarity_setting = polarity;
    settings_run++;
    queue_random(count);
  endtask

  // Sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(svpwm_duties(in_word));
        vectors_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (vectors_to_send.size() != 0) begin
          in_word <= vectors_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                      : $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall style is redrawn at random whenever its mode counter runs out
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(64, 512);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_style)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default: begin
          if (run_left == 0) begin
            out_stall <= !out_stall;
            run_left <= $urandom_range(1, 30);
          end else begin
            run_left <= run_left - 1;
          end
        end
      endcase
    end
  end

  // Check each delivered word against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected word: a=%0d b=%0d c=%0d sector=%0d",
                   out_word.compare_a, out_word.compare_b, out_word.compare_c,
                   out_word.sector_id);
      end else begin
        words_checked++;
        if (out_word.compare_a !== expected_words[0].compare_a ||
            out_word.compare_b !== expected_words[0].compare_b ||
            out_word.compare_c !== expected_words[0].compare_c ||
            out_word.sector_id !== expected_words[0].sector_id) begin
          faults++;
          if (faults <= 10)
            $display("mismatch: expected a=%0d b=%0d c=%0d sec=%0d, got a=%0d b=%0d c=%0d sec=%0d",
                     expected_words[0].compare_a, expected_words[0].compare_b,
                     expected_words[0].compare_c, expected_words[0].sector_id,
                     out_word.compare_a, out_word.compare_b, out_word.compare_c,
                     out_word.sector_id);
        end
        void'(expected_words.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: %0d words still expected", expected_words.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    queue_directed();
    queue_random(300);
    run_setting(16'd65535, 1'b1, 330);
    run_setting(16'd1, 1'b0, 250);
    run_setting(16'd0, 1'b1, 200);
    run_setting(16'($urandom_range(2, 65534)), 1'b0, 330);
    run_setting(16'($urandom_range(2, 65534)), 1'b1, 330);
    run_setting(16'd65535, 1'b0, 200);
    settle();
    faults += expected_words.size();
    $display("run covered %0d vectors across %0d period/polarity settings",
             vectors_sent, settings_run);
    $display("%0d duty words checked, %0d faults", words_checked, faults);
    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
